[hw/rtl/ggte_pkg.sv]
// shared types, codes and the gf(2^128) multiply for the ghash tag engine
`default_nettype none

package ggte_pkg;

  // item kinds on the input tuser
  localparam logic [1:0] OP_AAD    = 2'd0;
  localparam logic [1:0] OP_TEXT   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_HKEY_HI = 2'd0;
  localparam logic [1:0] REG_HKEY_LO = 2'd1;
  localparam logic [1:0] REG_MASK_HI = 2'd2;
  localparam logic [1:0] REG_MASK_LO = 2'd3;

  localparam int BLK_W   = 128;
  localparam int HALF_W  = 64;
  localparam int CNT_W   = 61;
  localparam int VB_W    = 5;
  localparam int BYTES   = 16;
  localparam int IN_TD_W = 136;
  localparam int OUT_TD_W = 256;

  localparam logic [VB_W-1:0] VB_FULL = 5'd16;

  // work item passed from front to back
  typedef struct packed {
    logic              fin;
    logic [BLK_W-1:0]  data;
  } ggte_item_t;

  // gcm bit order: bit 127 of the word holds the coefficient of x^0
  function automatic logic [BLK_W-1:0] gf128_mul(input logic [BLK_W-1:0] a,
                                                 input logic [BLK_W-1:0] b);
    logic [2*BLK_W-2:0] p;
    logic [BLK_W+6:0]   q;
    logic [BLK_W-1:0]   r;
    logic [BLK_W-1:0]   res;
    p = '0;
    // carry-less product, one xor tree per output coefficient
    for (int i = 0; i < BLK_W; i++) begin
      for (int j = 0; j < BLK_W; j++) begin
        p[i+j] = p[i+j] ^ (a[BLK_W-1-i] & b[BLK_W-1-j]);
      end
    end
    // first fold with x^128 = x^7 + x^2 + x + 1
    q = {7'b0, p[BLK_W-1:0]};
    for (int k = BLK_W; k < 2*BLK_W-1; k++) begin
      q[k-BLK_W]   = q[k-BLK_W]   ^ p[k];
      q[k-BLK_W+1] = q[k-BLK_W+1] ^ p[k];
      q[k-BLK_W+2] = q[k-BLK_W+2] ^ p[k];
      q[k-BLK_W+7] = q[k-BLK_W+7] ^ p[k];
    end
    // second fold of the few bits that spilled over
    r = q[BLK_W-1:0];
    for (int k = BLK_W; k < BLK_W+7; k++) begin
      r[k-BLK_W]   = r[k-BLK_W]   ^ q[k];
      r[k-BLK_W+1] = r[k-BLK_W+1] ^ q[k];
      r[k-BLK_W+2] = r[k-BLK_W+2] ^ q[k];
      r[k-BLK_W+7] = r[k-BLK_W+7] ^ q[k];
    end
    for (int i = 0; i < BLK_W; i++) begin
      res[BLK_W-1-i] = r[i];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ggte_front.sv]
// front end: accepts words, pads short blocks, keeps byte counts, builds length block
`default_nettype none

module ggte_front import ggte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_TD_W-1:0]   in_tdata,   // block_high, block_low, valid_bytes
  input  wire logic [1:0]           in_tuser,   // op
  input  wire logic                 q_ready,
  output logic                      q_push,
  output ggte_item_t                q_item
);

  logic [CNT_W-1:0]  aad_cnt_r, aad_cnt_nxt;
  logic [CNT_W-1:0]  txt_cnt_r, txt_cnt_nxt;
  logic              accept;
  logic [VB_W-1:0]   vb_raw;
  logic [VB_W-1:0]   vb;
  logic [BLK_W-1:0]  blk;
  logic [BLK_W-1:0]  byte_mask;

  assign in_tready = q_ready;
  assign accept    = in_tvalid & q_ready;

  // byte 0 is the top byte of block_high
  assign blk    = {in_tdata[63:0], in_tdata[127:64]};
  assign vb_raw = in_tdata[132:128];
  assign vb     = (vb_raw > VB_FULL) ? VB_FULL : vb_raw;

  // leading-byte mask for padding
  always_comb begin
    for (int b = 0; b < BYTES; b++) begin
      byte_mask[BLK_W-1-8*b -: 8] = {8{(VB_W'(b) < vb)}};
    end
  end

  // classify the word and update the counts
  always_comb begin
    aad_cnt_nxt = aad_cnt_r;
    txt_cnt_nxt = txt_cnt_r;
    q_push      = 1'b0;
    q_item.fin  = 1'b0;
    q_item.data = blk & byte_mask;
    unique case (in_tuser)
      OP_AAD: begin
        q_push = accept;
        if (accept) aad_cnt_nxt = aad_cnt_r + {{(CNT_W-VB_W){1'b0}}, vb};
      end
      OP_TEXT: begin
        q_push = accept;
        if (accept) txt_cnt_nxt = txt_cnt_r + {{(CNT_W-VB_W){1'b0}}, vb};
      end
      OP_FINISH: begin
        q_push      = accept;
        q_item.fin  = 1'b1;
        q_item.data = {aad_cnt_r, 3'b000, txt_cnt_r, 3'b000};
        if (accept) begin
          aad_cnt_nxt = '0;
          txt_cnt_nxt = '0;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // running byte counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aad_cnt_r <= '0;
      txt_cnt_r <= '0;
    end else begin
      aad_cnt_r <= aad_cnt_nxt;
      txt_cnt_r <= txt_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ggte_queue.sv]
// two-entry queue between the front end and the hash back end
`default_nettype none

module ggte_queue import ggte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  ggte_item_t       push_item,
  output logic             not_full,
  input  wire logic        pop,
  output logic             head_valid,
  output ggte_item_t       head_item
);

  ggte_item_t  ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign not_full   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = ~wr_ptr_r;
    if (pop)  rd_ptr_nxt = ~rd_ptr_r;
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

[hw/rtl/ggte_back.sv]
// back end: accumulator update Y = (Y ^ X) * H and the result register
`default_nettype none

module ggte_back import ggte_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_valid,
  input  ggte_item_t                 head_item,
  output logic                       pop,
  input  wire logic [BLK_W-1:0]      hkey,
  input  wire logic [BLK_W-1:0]      mask,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_TD_W-1:0]        out_tdata  // hash_high, hash_low, tag_high, tag_low
);

  logic [BLK_W-1:0]  acc_r, acc_nxt;
  logic [BLK_W-1:0]  prod;
  logic              out_vld_r, out_vld_nxt;
  logic [BLK_W-1:0]  hash_r;
  logic [BLK_W-1:0]  tag_r;
  logic              slot_free;

  // a finish item waits until the result register can take it
  assign slot_free = !out_vld_r || out_tready;
  assign pop       = head_valid && (!head_item.fin || slot_free);

  assign prod = gf128_mul(acc_r ^ head_item.data, hkey);

  always_comb begin
    acc_nxt     = acc_r;
    out_vld_nxt = out_vld_r && !out_tready;
    if (pop) begin
      acc_nxt = head_item.fin ? '0 : prod;
      if (head_item.fin) out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && head_item.fin) begin
      hash_r <= prod;
      tag_r  <= prod ^ mask;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {tag_r[HALF_W-1:0], tag_r[BLK_W-1:HALF_W],
                       hash_r[HALF_W-1:0], hash_r[BLK_W-1:HALF_W]};

endmodule

`default_nettype wire

[hw/rtl/gcm_ghash_tag_engine.sv]
// GCM GHASH and tag engine: APB register file, front end, queue and hash back end
//
// Input stream (in_*): one 128-bit block a word, tuser carries the op
// (AAD, ciphertext, finish), tdata the block and its valid byte count.
// Bytes past the count are zeroed before absorption. Finish folds in the
// length block and produces one result word; other ops produce none.
// Output stream (out_*): one word per finish with the hash and the tag
// (hash XOR E(K,J0)).
// APB port (cfg_*): hash subkey H and E(K,J0), 64-bit registers at 0, 8,
// 16 and 24; the user must write them only while the engine is idle; the
// block itself does not enforce it. Throughput: one word per cycle while
// the receiver keeps up, set by the combinational GF(2^128) multiply on
// the accumulator loop in the back end. A finish word passes the queue
// register and then the result register before it shows on out_tvalid.
// When the receiver stalls, the result is held and the back end stops at
// the next finish item; the two-entry queue then fills and in_tready drops.
// Reset clears the registers, the accumulator, the byte counts and the
// queue; no further initialisation is needed.
`default_nettype none

module gcm_ghash_tag_engine import ggte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_TD_W-1:0]   in_tdata,   // block_high, block_low, valid_bytes
  input  wire logic [1:0]           in_tuser,   // op
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_TD_W-1:0]       out_tdata,  // hash_high, hash_low, tag_high, tag_low
  // apb configuration
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [4:0]           cfg_paddr,
  input  wire logic [63:0]          cfg_pwdata,
  output logic [63:0]               cfg_prdata,
  output logic                      cfg_pready
);

  logic [HALF_W-1:0]  hkey_hi_r, hkey_lo_r;
  logic [HALF_W-1:0]  mask_hi_r, mask_lo_r;
  logic [1:0]         reg_idx;
  logic               cfg_we;
  logic               q_ready;
  logic               q_push;
  ggte_item_t         q_item;
  logic               q_pop;
  logic               head_valid;
  ggte_item_t         head_item;

  // register file
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hkey_hi_r <= '0;
      hkey_lo_r <= '0;
      mask_hi_r <= '0;
      mask_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_HKEY_HI: hkey_hi_r <= cfg_pwdata;
        REG_HKEY_LO: hkey_lo_r <= cfg_pwdata;
        REG_MASK_HI: mask_hi_r <= cfg_pwdata;
        REG_MASK_LO: mask_lo_r <= cfg_pwdata;
        default:     hkey_hi_r <= hkey_hi_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_HKEY_HI: cfg_prdata = hkey_hi_r;
      REG_HKEY_LO: cfg_prdata = hkey_lo_r;
      REG_MASK_HI: cfg_prdata = mask_hi_r;
      REG_MASK_LO: cfg_prdata = mask_lo_r;
      default:     cfg_prdata = '0;
    endcase
  end

  ggte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  ggte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .not_full   (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ggte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .hkey       ({hkey_hi_r, hkey_lo_r}),
    .mask       ({mask_hi_r, mask_lo_r}),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/ggte_checker.sv]
// port-level checker for the ghash tag engine, bound to the top level
`default_nettype none

module ggte_checker import ggte_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [1:0]           in_tuser,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_TD_W-1:0]  out_tdata,
  input wire logic                 cfg_psel,
  input wire logic                 cfg_penable,
  input wire logic                 cfg_pwrite,
  input wire logic                 cfg_pready,
  input wire logic [4:0]           cfg_paddr,
  input wire logic [63:0]          cfg_pwdata
);

  logic [HALF_W-1:0]  mask_hi_r, mask_lo_r;
  logic [2:0]         pend_r, pend_nxt;
  logic               fin_in;
  logic               res_out;
  logic               cfg_we;

  assign fin_in  = in_tvalid && in_tready && (in_tuser == OP_FINISH);
  assign res_out = out_tvalid && out_tready;
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // finishes accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    priority if (fin_in && !res_out) begin
      pend_nxt = pend_r + 3'd1;
    end else if (res_out && !fin_in) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  // shadow of the tag mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      mask_hi_r <= '0;
      mask_lo_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_we && cfg_paddr[4:3] == REG_MASK_HI) mask_hi_r <= cfg_pwdata;
      if (cfg_we && cfg_paddr[4:3] == REG_MASK_LO) mask_lo_r <= cfg_pwdata;
    end
  end

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid straight after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or vanished");

  a_result_has_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result word without an accepted finish");

  a_tag_is_masked_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[191:128] ^ out_tdata[63:0]) == mask_hi_r &&
                   (out_tdata[255:192] ^ out_tdata[127:64]) == mask_lo_r)
    else $error("tag differs from hash xor mask");

endmodule

bind gcm_ghash_tag_engine ggte_checker u_ggte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .in_tuser    (in_tuser),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata)
);

`default_nettype wire

[tb/gcm_tag_checker.sv]
`timescale 1ns / 100ps
// tag word checker: follows the engine's streams and apb writes, predicts and compares each tag word
module gcm_tag_checker import ggte_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [IN_TD_W-1:0]  in_tdata,   // block_high, block_low, valid_bytes
  input  wire logic [1:0]          in_tuser,   // op
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [OUT_TD_W-1:0] out_tdata,  // hash_high, hash_low, tag_high, tag_low
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [4:0]          cfg_paddr,
  input  wire logic [63:0]         cfg_pwdata,
  input  wire logic                cfg_pready,
  output int                       fail_count,
  output int                       pending,
  output int                       words_checked
);

  // reduction term of the gcm field, reflected bit order
  localparam logic [BLK_W-1:0] GCM_REDUCE = {8'he1, 120'd0};
  localparam int REPORT_MAX = 10;

  // laid out as on out_tdata, hash_high in the lowest bits
  typedef struct packed {
    logic [HALF_W-1:0] tag_lo;
    logic [HALF_W-1:0] tag_hi;
    logic [HALF_W-1:0] hash_lo;
    logic [HALF_W-1:0] hash_hi;
  } tag_word_t;

  tag_word_t        expected_tags[$];
  logic [BLK_W-1:0] hash_key;
  logic [BLK_W-1:0] mask_block;
  logic [BLK_W-1:0] ghash_acc;
  logic [CNT_W-1:0] hdr_total;
  logic [CNT_W-1:0] text_bytes;
  int               fails;
  int               checked;

  // y times h in gf(2^128), msb of y is the x^0 coefficient
  function automatic logic [BLK_W-1:0] gf_mul_key(input logic [BLK_W-1:0] y,
                                                  input logic [BLK_W-1:0] h);
    logic [BLK_W-1:0] z;
    logic [BLK_W-1:0] v;
    z = '0;
    v = h;
    for (int i = 0; i < BLK_W; i++) begin
      if (y[BLK_W-1-i]) z = z ^ v;
      v = v[0] ? ((v >> 1) ^ GCM_REDUCE) : (v >> 1);
    end
    return z;
  endfunction

  task automatic compare_field(input string name, input logic [HALF_W-1:0] want,
                               input logic [HALF_W-1:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tag_word_t        seen;
    tag_word_t        want;
    logic [BLK_W-1:0] blk;
    logic [VB_W-1:0]  vb;
    if (!rst_n) begin
      expected_tags.delete();
      hash_key   = '0;
      mask_block = '0;
      ghash_acc  = '0;
      hdr_total  = '0;
      text_bytes = '0;
      fails      = 0;
      checked    = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_HKEY_HI: hash_key[BLK_W-1:HALF_W]   = cfg_pwdata;
          REG_HKEY_LO: hash_key[HALF_W-1:0]       = cfg_pwdata;
          REG_MASK_HI: mask_block[BLK_W-1:HALF_W] = cfg_pwdata;
          REG_MASK_LO: mask_block[HALF_W-1:0]     = cfg_pwdata;
          default: begin end
        endcase
      end

      // result word against the oldest expectation
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (expected_tags.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("unexpected tag word: hash %h%h tag %h%h",
                     seen.hash_hi, seen.hash_lo, seen.tag_hi, seen.tag_lo);
        end else begin
          want = expected_tags.pop_front();
          compare_field("hash_high", want.hash_hi, seen.hash_hi);
          compare_field("hash_low", want.hash_lo, seen.hash_lo);
          compare_field("tag_high", want.tag_hi, seen.tag_hi);
          compare_field("tag_low", want.tag_lo, seen.tag_lo);
          checked++;
        end
      end

      // accepted input word
      if (in_tvalid && in_tready) begin
        blk = {in_tdata[HALF_W-1:0], in_tdata[BLK_W-1:HALF_W]};
        vb  = in_tdata[BLK_W +: VB_W];
        if (vb > VB_FULL) vb = VB_FULL;
        case (in_tuser)
          OP_AAD, OP_TEXT: begin
            // bytes past the count are dropped, byte 0 sits at the top
            blk = blk & ({BLK_W{1'b1}} << (8 * (BYTES - int'(vb))));
            ghash_acc = gf_mul_key(ghash_acc ^ blk, hash_key);
            if (in_tuser == OP_AAD) hdr_total = hdr_total + CNT_W'(vb);
            else text_bytes = text_bytes + CNT_W'(vb);
          end
          OP_FINISH: begin
            // length block in bits, aad count in the upper half
            ghash_acc = gf_mul_key(ghash_acc ^ {hdr_total, 3'b000, text_bytes, 3'b000},
                                   hash_key);
            want.hash_hi = ghash_acc[BLK_W-1:HALF_W];
            want.hash_lo = ghash_acc[HALF_W-1:0];
            want.tag_hi  = ghash_acc[BLK_W-1:HALF_W] ^ mask_block[BLK_W-1:HALF_W];
            want.tag_lo  = ghash_acc[HALF_W-1:0] ^ mask_block[HALF_W-1:0];
            expected_tags.push_back(want);
            ghash_acc  = '0;
            hdr_total  = '0;
            text_bytes = '0;
          end
          default: begin end  // reserved op leaves everything as it is
        endcase
      end
    end
    pending       <= expected_tags.size();
    fail_count    <= fails;
    words_checked <= checked;
  end

endmodule

[tb/gcm_ghash_tag_engine_test.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the ghash tag engine, checked by gcm_tag_checker
module gcm_ghash_tag_engine_test import ggte_pkg::*;;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 6;
  localparam int LIMIT_CYCLES = 400000;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic [IN_TD_W-1:0]  in_tdata    = '0;   // block_high, block_low, valid_bytes
  logic [1:0]          in_tuser    = OP_AAD; // op
  logic                out_tready  = 1'b0;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [4:0]          cfg_paddr   = '0;
  logic [63:0]         cfg_pwdata  = '0;
  wire logic                in_tready;
  wire logic                out_tvalid;
  wire logic [OUT_TD_W-1:0] out_tdata;  // hash_high, hash_low, tag_high, tag_low
  wire logic [63:0]         cfg_prdata;
  wire logic                cfg_pready;

  int fail_count;
  int pending;
  int words_checked;
  int words_sent    = 0;
  int finishes_sent = 0;
  int cycle_count   = 0;
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  int hold_req      = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  gcm_ghash_tag_engine u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gcm_tag_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_taken) begin
      out_tready <= 1'b0;
      hold_taken <= hold_req;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= !(rx_idle_on && $urandom_range(99) < 26);
    end
  end

  // mostly random blocks, with the all-zero and all-one extremes now and then
  function automatic logic [BLK_W-1:0] rand_block();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  // offer one word and hold it until it is taken
  task automatic push_word(input logic [1:0] op, input logic [BLK_W-1:0] blk,
                           input logic [VB_W-1:0] vb);
    if (tx_idle_on && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 26) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TD_W-BLK_W-VB_W){1'b0}}, vb, blk[HALF_W-1:0], blk[BLK_W-1:HALF_W]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_RSVD) words_sent++;
    if (op == OP_FINISH) finishes_sent++;
  endtask

  // stop sending until every tag word is back and the pipe has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write: setup then access
  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic load_keys(input logic [BLK_W-1:0] h, input logic [BLK_W-1:0] mask);
    reg_write(REG_HKEY_HI, h[BLK_W-1:HALF_W]);
    reg_write(REG_HKEY_LO, h[HALF_W-1:0]);
    reg_write(REG_MASK_HI, mask[BLK_W-1:HALF_W]);
    reg_write(REG_MASK_LO, mask[HALF_W-1:0]);
  endtask

  // well-formed message: aad, then ciphertext, last of each maybe short, then finish
  task automatic send_message(input int max_aad, input int max_text);
    int n_aad;
    int n_text;
    n_aad  = $urandom_range(max_aad);
    n_text = $urandom_range(max_text);
    for (int i = 0; i < n_aad; i++)
      push_word(OP_AAD, rand_block(),
                (i == n_aad - 1) ? VB_W'($urandom_range(1, 16)) : VB_FULL);
    for (int i = 0; i < n_text; i++)
      push_word(OP_TEXT, rand_block(),
                (i == n_text - 1) ? VB_W'($urandom_range(1, 16)) : VB_FULL);
    push_word(OP_FINISH, rand_block(), VB_W'($urandom_range(31)));
  endtask

  // random messages with some noise words of any op and count
  task automatic random_phase(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(9) != 0) send_message(3, 5);
      else push_word(2'($urandom_range(3)), rand_block(), VB_W'($urandom_range(31)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keys still at their reset value
    push_word(OP_AAD, rand_block(), VB_FULL);
    push_word(OP_TEXT, rand_block(), 5'd10);
    push_word(OP_FINISH, rand_block(), 5'd0);
    drain();

    // directed: count edges, zero and oversize counts, reserved op, order swaps
    load_keys(rand_block(), rand_block());
    push_word(OP_AAD, '1, VB_FULL);
    push_word(OP_AAD, '1, 5'd1);
    push_word(OP_AAD, '1, 5'd7);
    push_word(OP_AAD, rand_block(), 5'd8);
    push_word(OP_TEXT, '1, 5'd9);
    push_word(OP_TEXT, '1, 5'd15);
    push_word(OP_TEXT, rand_block(), 5'd0);
    push_word(OP_TEXT, '1, 5'd31);
    push_word(OP_TEXT, rand_block(), 5'd17);
    push_word(OP_RSVD, rand_block(), 5'd12);
    push_word(OP_FINISH, '1, 5'd31);
    push_word(OP_FINISH, rand_block(), VB_FULL);
    push_word(OP_TEXT, rand_block(), VB_FULL);
    push_word(OP_AAD, rand_block(), 5'd5);
    push_word(OP_FINISH, '0, 5'd0);
    push_word(OP_AAD, '0, VB_FULL);
    push_word(OP_FINISH, rand_block(), 5'd3);
    push_word(OP_RSVD, '1, 5'd0);
    push_word(OP_TEXT, '0, 5'd0);
    push_word(OP_FINISH, '0, 5'd0);
    drain();

    // random keys, idling on both sides
    load_keys(rand_block(), rand_block());
    random_phase(470);
    drain();

    // identity key and zero mask, no idling at all
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    load_keys({1'b1, {(BLK_W-1){1'b0}}}, '0);
    random_phase(470);
    drain();

    // all-one key and mask; receiver holds off while short messages pile up
    load_keys('1, '1);
    rx_idle_on <= 1'b1;
    hold_req   <= hold_req + 1;
    repeat (12) send_message(1, 1);
    tx_idle_on = 1'b1;
    random_phase(490);
    drain();

    // fresh random keys
    load_keys(rand_block(), rand_block());
    random_phase(470);
    drain();

    $display("run: %0d input words with %0d finishes, %0d tag words checked, five key sets",
             words_sent, finishes_sent, words_checked);
    $display("covered short, empty and oversize counts, reserved ops, a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ggte_pkg.sv
hw/rtl/ggte_front.sv
hw/rtl/ggte_queue.sv
hw/rtl/ggte_back.sv
hw/rtl/gcm_ghash_tag_engine.sv
hw/rtl/ggte_checker.sv
tb/gcm_tag_checker.sv
tb/gcm_ghash_tag_engine_test.sv
